@@ rtl/best_fit_index_range_allocator_unit_assert.svh @@
`ifndef BEST_FIT_INDEX_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_INDEX_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
// implication check under reset
`define BFA_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle check under reset
`define BFA_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/bfa_pkg.sv @@
package bfa_pkg;
    localparam int MaxSeg = 64;
    localparam int IdxBits = 16;
    localparam int SegW = $clog2(MaxSeg);
    localparam int CntW = $clog2(MaxSeg + 1);
    localparam int PosW = IdxBits + 1;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FIT = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
    localparam logic [2:0] ST_FULL = 3'd5;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_LENGTH = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic            used;
        logic [PosW-1:0] len;
        logic [PosW-1:0] start;
    } seg_t;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_NEXT, S_DECIDE, S_MOVE, S_FIX, S_DONE
    } state_t;
endpackage

@@ rtl/best_fit_index_range_allocator_unit.sv @@
// flow: an allocate or unmatched release scans the whole table in S_SCAN, then S_DECIDE, before its word;
// a matched release of entry k stops the scan there and goes to S_NEXT; bad size or out of range answers from S_SCAN
// a split adds the S_FIX write; a split or merge that moves m > 0 table entries adds an S_MOVE pass
// one word in flight; the next word is taken once the result is taken and no config write is pending
// reset: async; the table returns to one free segment (base 0, length 1024), written in
// S_INIT after reset; a config write restarts the table to one free segment the same way
module best_fit_index_range_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_size[15:0], release_start[32:16], zero pad
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_index[16:0], status[19:17], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import bfa_pkg::*;

    `include "best_fit_index_range_allocator_unit_assert.svh"

    // segment table, one read and one write per cycle
    seg_t seg_mem [MaxSeg];
    seg_t rd_reg;
    logic [SegW-1:0] rd_addr;
    logic wr_en;
    logic [SegW-1:0] wr_addr;
    seg_t wr_data;

    logic [CntW-1:0] cnt_reg;
    logic [IdxBits-1:0] base_reg, len_reg;

    state_t state_reg, state_next;
    logic func_reg;
    logic [IdxBits-1:0] size_reg;
    logic [PosW-1:0] rel_reg;
    logic [PosW-1:0] res_idx_reg;
    logic [2:0] res_st_reg;

    // scan pipeline: a_reg is the read address, ri_reg the entry now in rd_reg
    logic [CntW-1:0] a_reg;
    logic rv_reg;
    logic [SegW-1:0] ri_reg;
    logic found_reg;
    logic [SegW-1:0] best_reg;
    logic [PosW-1:0] best_len_reg;
    logic [PosW-1:0] best_st_reg;
    seg_t prev_reg;

    // table move: read mv_src_reg, write that word in the next cycle at mv_dst_reg
    logic mv_go_reg;
    logic mv_rv_reg;
    logic mv_up_reg;
    logic mv_two_reg;
    logic [SegW-1:0] mv_src_reg;
    logic [SegW-1:0] mv_last_reg;
    logic [SegW-1:0] mv_dst_reg;

    logic [PosW:0] end_w;
    logic [SegW-1:0] last_w;
    logic bad_w;
    logic issue_w;
    logic scan_end;
    logic fit_w;
    logic hit_w;
    logic split_w;
    logic full_w;
    logic right_ok_w;
    logic right_free_w;
    logic left_free_w;
    logic [SegW-1:0] best_p1;
    logic [SegW-1:0] best_m1;
    logic [PosW-1:0] merge_len_w;
    logic [PosW-1:0] merge_st_w;
    logic [CntW-1:0] mv_src_w;
    logic need_mv_w;

    assign end_w = {2'b00, base_reg} + {2'b00, len_reg};
    assign last_w = SegW'(cnt_reg - CntW'(1));
    assign bad_w = (func_reg == OP_RELEASE)
        ? (rel_reg < {1'b0, base_reg} || {1'b0, rel_reg} > end_w)
        : (size_reg == '0);
    assign issue_w = (a_reg < cnt_reg);
    assign scan_end = rv_reg && (ri_reg == last_w);
    assign fit_w = !rd_reg.used && rd_reg.len >= {1'b0, size_reg}
        && (!found_reg || rd_reg.len < best_len_reg);
    assign hit_w = rd_reg.used && rd_reg.start == rel_reg;
    assign split_w = best_len_reg > {1'b0, size_reg};
    assign full_w = cnt_reg >= CntW'(MaxSeg);
    assign best_p1 = best_reg + SegW'(1);
    assign best_m1 = best_reg - SegW'(1);
    assign right_ok_w = ({1'b0, best_reg} + CntW'(1)) < cnt_reg;
    // in S_NEXT rd_reg holds the entry after the released one
    assign right_free_w = right_ok_w && !rd_reg.used;
    assign left_free_w = (best_reg != '0) && !prev_reg.used;
    assign merge_len_w = (left_free_w ? prev_reg.len : PosW'(0)) + best_len_reg
        + (right_free_w ? rd_reg.len : PosW'(0));
    assign merge_st_w = left_free_w ? prev_reg.start : best_st_reg;
    assign mv_src_w = {1'b0, best_reg} + (right_free_w ? CntW'(2) : CntW'(1));
    assign need_mv_w = (left_free_w || right_free_w) && (mv_src_w < cnt_reg);

    assign s_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata = {4'd0, res_st_reg, res_idx_reg};

    always_comb
    begin
        state_next = state_reg;
        rd_addr = a_reg[SegW-1:0];
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (state_reg)
            S_INIT:
            begin
                wr_en = 1'b1;
                wr_data = {1'b0, 1'b0, len_reg, 1'b0, base_reg};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    wr_en = 1'b1;
                    if (cfg_index == CFG_POOL_BASE)
                        wr_data = {1'b0, 1'b0, len_reg, 1'b0, cfg_data};
                    else
                        wr_data = {1'b0, 1'b0, cfg_data, 1'b0, base_reg};
                end
                else if (s_tvalid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (bad_w)
                    state_next = S_DONE;
                else if (rv_reg && func_reg == OP_RELEASE && hit_w)
                    state_next = S_NEXT;
                else if (scan_end)
                    state_next = S_DECIDE;
            end
            S_NEXT:
            begin
                // free the released entry and fold in free neighbors
                wr_en = 1'b1;
                wr_addr = left_free_w ? best_m1 : best_reg;
                wr_data = {1'b0, merge_len_w, merge_st_w};
                state_next = need_mv_w ? S_MOVE : S_DONE;
            end
            S_DECIDE:
            begin
                if (found_reg && !(split_w && full_w))
                begin
                    wr_en = 1'b1;
                    wr_addr = best_reg;
                    wr_data = {1'b1, 1'b0, size_reg, best_st_reg};
                    if (split_w)
                        state_next = right_ok_w ? S_MOVE : S_FIX;
                    else
                        state_next = S_DONE;
                end
                else
                    state_next = S_DONE;
            end
            S_MOVE:
            begin
                rd_addr = mv_src_reg;
                if (mv_rv_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = mv_dst_reg;
                    wr_data = rd_reg;
                    if (!mv_go_reg)
                        state_next = mv_up_reg ? S_FIX : S_DONE;
                end
            end
            S_FIX:
            begin
                // remainder of the split goes just after the allocated entry
                wr_en = 1'b1;
                wr_addr = best_p1;
                wr_data = {1'b0, best_len_reg - {1'b0, size_reg},
                           best_st_reg + {1'b0, size_reg}};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            seg_mem[wr_addr] <= wr_data;
        rd_reg <= seg_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            len_reg <= IdxBits'(1024);
            cnt_reg <= CntW'(1);
            func_reg <= 1'b0;
            size_reg <= '0;
            rel_reg <= '0;
            a_reg <= '0;
            rv_reg <= 1'b0;
            ri_reg <= '0;
            found_reg <= 1'b0;
            best_reg <= '0;
            best_len_reg <= '0;
            best_st_reg <= '0;
            prev_reg <= '0;
            mv_go_reg <= 1'b0;
            mv_rv_reg <= 1'b0;
            mv_up_reg <= 1'b0;
            mv_two_reg <= 1'b0;
            mv_src_reg <= '0;
            mv_last_reg <= '0;
            mv_dst_reg <= '0;
            res_idx_reg <= '0;
            res_st_reg <= ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_POOL_BASE)
                            base_reg <= cfg_data;
                        else
                            len_reg <= cfg_data;
                        cnt_reg <= CntW'(1);
                    end
                    else if (s_tvalid)
                    begin
                        func_reg <= s_tuser;
                        size_reg <= s_tdata[15:0];
                        rel_reg <= s_tdata[32:16];
                        a_reg <= '0;
                        rv_reg <= 1'b0;
                        found_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (bad_w)
                    begin
                        res_idx_reg <= '0;
                        res_st_reg <= (func_reg == OP_RELEASE) ? ST_RANGE : ST_BAD_SIZE;
                    end
                    else
                    begin
                        if (issue_w)
                            a_reg <= a_reg + CntW'(1);
                        rv_reg <= issue_w;
                        ri_reg <= a_reg[SegW-1:0];
                        if (rv_reg)
                        begin
                            if (func_reg == OP_RELEASE)
                            begin
                                if (hit_w)
                                begin
                                    found_reg <= 1'b1;
                                    best_reg <= ri_reg;
                                    best_len_reg <= rd_reg.len;
                                    best_st_reg <= rd_reg.start;
                                end
                                else
                                    prev_reg <= rd_reg;
                            end
                            else if (fit_w)
                            begin
                                found_reg <= 1'b1;
                                best_reg <= ri_reg;
                                best_len_reg <= rd_reg.len;
                                best_st_reg <= rd_reg.start;
                            end
                        end
                    end
                end
                S_NEXT:
                begin
                    res_st_reg <= ST_OK;
                    res_idx_reg <= rel_reg;
                    if (left_free_w && right_free_w)
                        cnt_reg <= cnt_reg - CntW'(2);
                    else if (left_free_w || right_free_w)
                        cnt_reg <= cnt_reg - CntW'(1);
                    mv_src_reg <= mv_src_w[SegW-1:0];
                    mv_last_reg <= last_w;
                    mv_up_reg <= 1'b0;
                    mv_two_reg <= left_free_w && right_free_w;
                    mv_go_reg <= 1'b1;
                    mv_rv_reg <= 1'b0;
                end
                S_DECIDE:
                begin
                    res_idx_reg <= '0;
                    if (!found_reg)
                        res_st_reg <= (func_reg == OP_RELEASE) ? ST_NOT_ALLOC : ST_NO_FIT;
                    else if (split_w && full_w)
                        res_st_reg <= ST_FULL;
                    else
                    begin
                        res_st_reg <= ST_OK;
                        res_idx_reg <= best_st_reg;
                        if (split_w)
                        begin
                            cnt_reg <= cnt_reg + CntW'(1);
                            mv_src_reg <= last_w;
                            mv_last_reg <= best_p1;
                            mv_up_reg <= 1'b1;
                            mv_two_reg <= 1'b0;
                            mv_go_reg <= 1'b1;
                            mv_rv_reg <= 1'b0;
                        end
                    end
                end
                S_MOVE:
                begin
                    if (mv_go_reg)
                    begin
                        mv_rv_reg <= 1'b1;
                        mv_dst_reg <= mv_up_reg ? mv_src_reg + SegW'(1)
                            : mv_src_reg - (mv_two_reg ? SegW'(2) : SegW'(1));
                        if (mv_src_reg == mv_last_reg)
                            mv_go_reg <= 1'b0;
                        else
                            mv_src_reg <= mv_up_reg ? mv_src_reg - SegW'(1)
                                : mv_src_reg + SegW'(1);
                    end
                    else
                        mv_rv_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    `BFA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg != '0 && cnt_reg <= CntW'(MaxSeg))
    `BFA_ASSERT_IMP(a_ready_excl, m_tvalid, !s_tready)
    `BFA_ASSERT_NXT(a_start_scan, s_tvalid && s_tready, state_reg == S_SCAN)
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bfa_pkg::*;

    localparam int HALF = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE = 250;

    typedef struct packed {
        bit          func;
        logic [15:0] size;
        logic [16:0] rel;
    } request_t;

    typedef struct packed {
        logic [16:0] idx;
        logic [2:0]  st;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    best_fit_index_range_allocator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #HALF clk = ~clk;

    // allocator shadow state
    int unsigned pool_base_q = 0;
    int unsigned pool_len_q = 1024;
    int unsigned seg_start [MaxSeg];
    int unsigned seg_len [MaxSeg];
    bit          seg_used [MaxSeg];
    int unsigned seg_n;

    request_t pending_reqs [$];
    answer_t  expected_answers [$];
    int       errors = 0;
    int       n_sent = 0;
    int       n_answers = 0;
    int       status_seen [8];

    logic s_fire = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   rdy_mode = 0;
    bit   hold_go = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    function automatic void table_clear();
        for (int i = 0; i < MaxSeg; i++)
        begin
            seg_start[i] = 0;
            seg_len[i] = 0;
            seg_used[i] = 1'b0;
        end
        seg_start[0] = pool_base_q;
        seg_len[0] = pool_len_q;
        seg_n = 1;
    endfunction

    function automatic void seg_drop(int unsigned at);
        for (int unsigned i = at; i + 1 < seg_n; i++)
        begin
            seg_start[i] = seg_start[i + 1];
            seg_len[i] = seg_len[i + 1];
            seg_used[i] = seg_used[i + 1];
        end
        seg_n--;
        seg_start[seg_n] = 0;
        seg_len[seg_n] = 0;
        seg_used[seg_n] = 1'b0;
    endfunction

    function automatic answer_t allocate_or_release(request_t r);
        answer_t a;
        int unsigned best;
        int unsigned hit;
        int unsigned s;
        a.idx = '0;
        a.st = ST_OK;
        if (r.func == OP_ALLOC)
        begin
            best = MaxSeg;
            if (r.size == 0)
            begin
                a.st = ST_BAD_SIZE;
                return a;
            end
            for (int unsigned i = 0; i < seg_n; i++)
                if (!seg_used[i] && seg_len[i] >= r.size &&
                    (best == MaxSeg || seg_len[i] < seg_len[best]))
                    best = i;
            if (best == MaxSeg)
            begin
                a.st = ST_NO_FIT;
                return a;
            end
            if (seg_len[best] > r.size)
            begin
                if (seg_n >= MaxSeg)
                begin
                    a.st = ST_FULL;
                    return a;
                end
                // open a slot just after the chosen segment for the remainder
                for (int unsigned i = seg_n; i > best + 1; i--)
                begin
                    seg_start[i] = seg_start[i - 1];
                    seg_len[i] = seg_len[i - 1];
                    seg_used[i] = seg_used[i - 1];
                end
                seg_start[best + 1] = seg_start[best] + r.size;
                seg_len[best + 1] = seg_len[best] - r.size;
                seg_used[best + 1] = 1'b0;
                seg_n++;
                seg_len[best] = r.size;
            end
            seg_used[best] = 1'b1;
            a.idx = 17'(seg_start[best]);
        end
        else
        begin
            s = r.rel;
            hit = MaxSeg;
            if (s < pool_base_q || s > pool_base_q + pool_len_q)
            begin
                a.st = ST_RANGE;
                return a;
            end
            for (int unsigned i = 0; i < seg_n; i++)
                if (hit == MaxSeg && seg_used[i] && seg_start[i] == s)
                    hit = i;
            if (hit == MaxSeg)
            begin
                a.st = ST_NOT_ALLOC;
                return a;
            end
            seg_used[hit] = 1'b0;
            if (hit + 1 < seg_n && !seg_used[hit + 1])
            begin
                seg_len[hit] += seg_len[hit + 1];
                seg_drop(hit + 1);
            end
            if (hit > 0 && !seg_used[hit - 1])
            begin
                seg_len[hit - 1] += seg_len[hit];
                seg_drop(hit);
            end
            a.idx = 17'(s);
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender: bursts of words with random gaps
    always @(negedge clk)
    begin
        if (!s_tvalid || s_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                request_t r;
                r = pending_reqs.pop_front();
                s_tdata <= {7'b0, r.rel, r.size};
                s_tuser <= r.func;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_go && !hold_done && hold_left == 0)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= (hold_left == 1);
        end
        else
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                default: m_tready <= ($urandom_range(0, 15) != 0) && ($urandom_range(0, 2) != 0);
            endcase
    end

    // monitor and checker
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        s_fire <= s_tvalid && s_tready;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POOL_BASE)
                pool_base_q = cfg_data;
            else
                pool_len_q = cfg_data;
            table_clear();
        end
        if (s_tvalid && s_tready)
        begin
            request_t r;
            r.func = s_tuser;
            r.size = s_tdata[15:0];
            r.rel = s_tdata[32:16];
            expected_answers.push_back(allocate_or_release(r));
            n_sent++;
        end
        if (m_tvalid && m_tready)
        begin
            got.idx = m_tdata[16:0];
            got.st = m_tdata[19:17];
            n_answers++;
            if (expected_answers.size() == 0)
                report_mismatch("unexpected word status", got.st, -1);
            else
            begin
                want = expected_answers.pop_front();
                status_seen[want.st]++;
                if (got.st !== want.st)
                    report_mismatch("status", got.st, want.st);
                if (got.idx !== want.idx)
                    report_mismatch("result_index", got.idx, want.idx);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_req(bit f, int unsigned size, int unsigned rel);
        request_t r;
        r.func = f;
        r.size = 16'(size);
        r.rel = 17'(rel);
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic which, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int alloc_pct);
        int unsigned live [$];
        int unsigned size;
        int unsigned rel;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            while (pending_reqs.size() >= 4)
                @(posedge clk);
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    size = $urandom_range(1, 12);
                else if (pick < 85)
                    size = $urandom_range(1, (pool_len_q > 0) ? pool_len_q : 1);
                else if (pick < 90)
                    size = 0;
                else
                    size = $urandom_range(0, 16'hffff);
                push_req(OP_ALLOC, size, $urandom_range(0, 17'h1ffff));
            end
            else
            begin
                live.delete();
                for (int unsigned i = 0; i < seg_n; i++)
                    if (seg_used[i])
                        live.push_back(seg_start[i]);
                pick = $urandom_range(0, 99);
                if (live.size() > 0 && pick < 75)
                    rel = live[$urandom_range(0, live.size() - 1)];
                else if (pick < 88)
                    rel = $urandom_range(0, 17'h1ffff);
                else
                    rel = pool_base_q + $urandom_range(0, pool_len_q);
                push_req(OP_RELEASE, $urandom_range(0, 16'hffff), rel);
            end
        end
        drain();
    endtask

    initial
    begin
        table_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part on the reset pool, base 0 length 1024
        push_req(OP_ALLOC, 0, 17'h1ffff);
        push_req(OP_ALLOC, 16'hffff, 0);
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_RELEASE, 16'hffff, 0);
        push_req(OP_ALLOC, 16, 0);
        push_req(OP_ALLOC, 100, 0);
        push_req(OP_RELEASE, 0, 1024);
        push_req(OP_RELEASE, 0, 1025);
        push_req(OP_RELEASE, 0, 17'h1ffff);
        push_req(OP_RELEASE, 0, 5);
        push_req(OP_RELEASE, 0, 0);
        push_req(OP_ALLOC, 8, 0);
        push_req(OP_RELEASE, 0, 16);
        push_req(OP_RELEASE, 0, 0);
        drain();

        write_reg(CFG_POOL_BASE, 16'hffff);
        write_reg(CFG_POOL_LENGTH, 16'hffff);
        push_req(OP_RELEASE, 0, 16'hfffe);
        push_req(OP_RELEASE, 0, 17'h1fffe);
        push_req(OP_ALLOC, 16'hffff, 0);
        push_req(OP_RELEASE, 0, 17'h1ffff);
        push_req(OP_RELEASE, 0, 16'hffff);
        drain();

        write_reg(CFG_POOL_LENGTH, 16'h0000);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_RELEASE, 0, 16'hffff);
        drain();

        // random part over several pool settings
        write_reg(CFG_POOL_BASE, 16'h0000);
        write_reg(CFG_POOL_LENGTH, 16'd1024);
        rdy_mode = 0;
        random_phase(450, 60);

        rdy_mode = 1;
        hold_go = 1'b1;
        random_phase(400, 55);

        write_reg(CFG_POOL_BASE, 16'($urandom_range(0, 16'hffff)));
        write_reg(CFG_POOL_LENGTH, 16'($urandom_range(64, 2000)));
        rdy_mode = 2;
        random_phase(400, 55);

        write_reg(CFG_POOL_BASE, 16'hffff);
        write_reg(CFG_POOL_LENGTH, 16'hffff);
        rdy_mode = 1;
        random_phase(300, 55);

        write_reg(CFG_POOL_BASE, 16'($urandom_range(0, 16'hffff)));
        write_reg(CFG_POOL_LENGTH, 16'($urandom_range(0, 40)));
        rdy_mode = 0;
        random_phase(200, 50);

        write_reg(CFG_POOL_LENGTH, 16'h0000);
        random_phase(130, 50);

        drain();
        $display("ran %0d requests and checked %0d result words over six random phases",
                 n_sent, n_answers);
        $display("status counts: ok %0d bad size %0d no fit %0d range %0d unalloc %0d full %0d",
                 status_seen[ST_OK], status_seen[ST_BAD_SIZE], status_seen[ST_NO_FIT],
                 status_seen[ST_RANGE], status_seen[ST_NOT_ALLOC], status_seen[ST_FULL]);
        if (errors == 0 && expected_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/bfa_pkg.sv
rtl/best_fit_index_range_allocator_unit.sv
tb/tb.sv
